// ===== sv/erot_pkg.sv =====
// shared types, constants and helpers for the euler rotation unit
`default_nettype none
package erot_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int TURN_BITS    = 32;
	localparam int CW           = 34;
	localparam int ZW           = 33;
	localparam int TRIG_BITS    = 16;
	localparam int PAIR_BITS    = 32;
	localparam int ENTRY_BITS   = 48;
	localparam int PAD_BITS     = 48;
	localparam int SPLIT        = 24;
	localparam int PART_BITS    = 50;
	localparam int ACC_BITS     = 96;
	localparam int FRAC_SHIFT   = 45;

	// front: stage 0, one stage per cordic step, one fold stage
	localparam int FRONT_LAT = CORDIC_STEPS + 2;
	localparam int BACK_LAT  = 7;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
	localparam logic signed [CW-1:0] HALF_Q15    = 34'sd16384;
	localparam logic [CW-1:0]        Q15_MAX     = 34'd32767;

	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef logic signed [TRIG_BITS-1:0] trig_t;

	typedef struct packed {
		trig_t sa;
		trig_t ca;
		trig_t sb;
		trig_t cb;
		trig_t sc;
		trig_t cc;
	} trig_set_t;

	// clamp to [0, 1.0], round half up to q1.15, cap at 32767
	function automatic trig_t to_q15(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] c;
		logic [CW-1:0] r;
		if (v < 0) begin
			c = '0;
		end else if (v > ONE_Q30) begin
			c = ONE_Q30;
		end else begin
			c = v;
		end
		r = CW'(unsigned'(c + HALF_Q15)) >> 15;
		if (r > Q15_MAX) begin
			r = Q15_MAX;
		end
		return trig_t'(r[TRIG_BITS-1:0]);
	endfunction

endpackage
`default_nettype wire

// ===== sv/erot_fifo.sv =====
// small register queue with a combinational head
`default_nettype none
module erot_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

	assign rdata = mem_q[rd_q];
	assign empty = (cnt_q == '0);
endmodule
`default_nettype wire

// ===== sv/erot_sincos.sv =====
// pipelined cordic sine and cosine with quadrant folding
`default_nettype none
module erot_sincos
	import erot_pkg::*;
#(
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic [ANGLE_BITS-1:0] angle,
	output trig_t                      sin_val,
	output trig_t                      cos_val
);
	logic [TURN_BITS-1:0] turn;
	logic signed [CW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_s [CORDIC_STEPS+1];
	logic [1:0] quad_s [CORDIC_STEPS+1];
	trig_t cq, sq;

	assign turn = {angle, {(TURN_BITS-ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk) begin
		x_s[0]    <= CORDIC_GAIN;
		y_s[0]    <= '0;
		z_s[0]    <= $signed({3'b000, turn[TURN_BITS-3:0]});
		quad_s[0] <= turn[TURN_BITS-1:TURN_BITS-2];
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			quad_s[i+1] <= quad_s[i];
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - $signed({1'b0, ATAN_TURN[i]});
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + $signed({1'b0, ATAN_TURN[i]});
			end
		end
	end

	assign cq = to_q15(x_s[CORDIC_STEPS]);
	assign sq = to_q15(y_s[CORDIC_STEPS]);

	always_ff @(posedge clk) begin
		case (quad_s[CORDIC_STEPS])
			2'd0: begin
				cos_val <= cq;
				sin_val <= sq;
			end
			2'd1: begin
				cos_val <= -sq;
				sin_val <= cq;
			end
			2'd2: begin
				cos_val <= -cq;
				sin_val <= -sq;
			end
			default: begin
				cos_val <= sq;
				sin_val <= -cq;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== sv/erot_front.sv =====
// front end: sines and cosines of the three angles, point carried alongside
`default_nettype none
module erot_front
	import erot_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic [3*COORD_BITS-1:0] in_point,
	input  wire logic [ANGLE_BITS-1:0]   angle_x,
	input  wire logic [ANGLE_BITS-1:0]   angle_y,
	input  wire logic [ANGLE_BITS-1:0]   angle_z,
	output logic                         out_valid,
	output logic      [3*COORD_BITS-1:0] out_point,
	output trig_set_t                    out_trig
);
	logic [FRONT_LAT-1:0] valid_q;
	logic [3*COORD_BITS-1:0] pt_s [FRONT_LAT];

	erot_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_a (
		.clk(clk), .angle(angle_x), .sin_val(out_trig.sa), .cos_val(out_trig.ca)
	);
	erot_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_b (
		.clk(clk), .angle(angle_y), .sin_val(out_trig.sb), .cos_val(out_trig.cb)
	);
	erot_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_c (
		.clk(clk), .angle(angle_z), .sin_val(out_trig.sc), .cos_val(out_trig.cc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[FRONT_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		pt_s[0] <= in_point;
		for (int i = 1; i < FRONT_LAT; i++) begin
			pt_s[i] <= pt_s[i-1];
		end
	end

	assign out_valid = valid_q[FRONT_LAT-1];
	assign out_point = pt_s[FRONT_LAT-1];
endmodule
`default_nettype wire

// ===== sv/erot_back.sv =====
// back end: matrix entries, split products, row sums, rounding and saturation
`default_nettype none
module erot_back
	import erot_pkg::*;
#(
	parameter int COORD_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic [3*COORD_BITS-1:0] in_point,
	input  trig_set_t                    in_trig,
	output logic                         out_valid,
	output logic      [3*COORD_BITS:0]   out_data
);
	localparam logic signed [ACC_BITS-1:0] SMAX =
		(ACC_BITS'(1) <<< (COORD_BITS - 1)) - ACC_BITS'(1);
	localparam logic signed [ACC_BITS-1:0] SMIN = -SMAX - ACC_BITS'(1);
	localparam logic signed [ACC_BITS-1:0] HALF_LSB = ACC_BITS'(1) <<< (FRAC_SHIFT - 1);

	typedef logic signed [PAIR_BITS-1:0] pair_t;
	typedef logic signed [ENTRY_BITS-1:0] entry_t;
	typedef logic signed [PART_BITS-1:0] part_t;
	typedef logic signed [ACC_BITS-1:0] acc_t;

	function automatic entry_t sh15(input pair_t p);
		return entry_t'(p) <<< 15;
	endfunction

	logic [BACK_LAT-1:0] valid_q;
	logic [3*COORD_BITS-1:0] pt_s1, pt_s2;
	pair_t cbcc_s1, sccb_s1, cacc_s1, scca_s1, sasb_s1, sacb_s1, cacb_s1, sasc_s1;
	pair_t sacc_s1, sbca_s1;
	trig_t cc_s1, sc_s1, sb_s1;
	entry_t e_s2 [9];
	part_t hh_s3 [9], hl_s3 [9], lh_s3 [9], ll_s3 [9];
	acc_t term_s4 [9];
	acc_t pa_s5 [3], pb_s5 [3];
	acc_t sum_s6 [3];
	logic [COORD_BITS-1:0] res_s7 [3];
	logic sat_s7;
	entry_t m_a, m_b, m_c, m_d;
	logic signed [PAD_BITS-1:0] pad [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[BACK_LAT-2:0], in_valid};
		end
	end

	// pairwise trig products
	always_ff @(posedge clk) begin
		cbcc_s1 <= in_trig.cb * in_trig.cc;
		sccb_s1 <= in_trig.sc * in_trig.cb;
		cacc_s1 <= in_trig.ca * in_trig.cc;
		scca_s1 <= in_trig.sc * in_trig.ca;
		sasb_s1 <= in_trig.sa * in_trig.sb;
		sacb_s1 <= in_trig.sa * in_trig.cb;
		cacb_s1 <= in_trig.ca * in_trig.cb;
		sasc_s1 <= in_trig.sa * in_trig.sc;
		sacc_s1 <= in_trig.sa * in_trig.cc;
		sbca_s1 <= in_trig.sb * in_trig.ca;
		cc_s1   <= in_trig.cc;
		sc_s1   <= in_trig.sc;
		sb_s1   <= in_trig.sb;
		pt_s1   <= in_point;
	end

	assign m_a = entry_t'(sasb_s1) * entry_t'(cc_s1);
	assign m_b = entry_t'(sasb_s1) * entry_t'(sc_s1);
	assign m_c = entry_t'(sbca_s1) * entry_t'(cc_s1);
	assign m_d = entry_t'(sbca_s1) * entry_t'(sc_s1);

	// matrix entries in units of 2^-45
	always_ff @(posedge clk) begin
		e_s2[0] <= sh15(cbcc_s1);
		e_s2[1] <= -sh15(sccb_s1);
		e_s2[2] <= entry_t'(sb_s1) <<< 30;
		e_s2[3] <= m_a + sh15(scca_s1);
		e_s2[4] <= sh15(cacc_s1) - m_b;
		e_s2[5] <= -sh15(sacb_s1);
		e_s2[6] <= sh15(sasc_s1) - m_c;
		e_s2[7] <= sh15(sacc_s1) + m_d;
		e_s2[8] <= sh15(cacb_s1);
		pt_s2   <= pt_s1;
	end

	// x sits in the top bits of the packed point
	for (genvar j = 0; j < 3; j++) begin : g_pad
		assign pad[j] = PAD_BITS'($signed(pt_s2[(2-j)*COORD_BITS +: COORD_BITS]));
	end

	// each entry times coordinate as four half-width partial products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			hh_s3[k] <= PART_BITS'($signed(e_s2[k][ENTRY_BITS-1:SPLIT]) *
				$signed(pad[k%3][PAD_BITS-1:SPLIT]));
			hl_s3[k] <= PART_BITS'($signed(e_s2[k][ENTRY_BITS-1:SPLIT]) *
				$signed({1'b0, pad[k%3][SPLIT-1:0]}));
			lh_s3[k] <= PART_BITS'($signed({1'b0, e_s2[k][SPLIT-1:0]}) *
				$signed(pad[k%3][PAD_BITS-1:SPLIT]));
			ll_s3[k] <= PART_BITS'($signed({1'b0, e_s2[k][SPLIT-1:0]}) *
				$signed({1'b0, pad[k%3][SPLIT-1:0]}));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			term_s4[k] <= (acc_t'(hh_s3[k]) <<< (2*SPLIT)) + (acc_t'(hl_s3[k]) <<< SPLIT) +
				(acc_t'(lh_s3[k]) <<< SPLIT) + acc_t'(ll_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			pa_s5[r] <= term_s4[3*r] + term_s4[3*r+1];
			pb_s5[r] <= term_s4[3*r+2] + HALF_LSB;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			sum_s6[r] <= pa_s5[r] + pb_s5[r];
		end
	end

	always_ff @(posedge clk) begin
		logic any_sat;
		acc_t v;
		any_sat = 1'b0;
		for (int r = 0; r < 3; r++) begin
			v = sum_s6[r] >>> FRAC_SHIFT;
			if (v > SMAX) begin
				v = SMAX;
				any_sat = 1'b1;
			end else if (v < SMIN) begin
				v = SMIN;
				any_sat = 1'b1;
			end
			res_s7[r] <= v[COORD_BITS-1:0];
		end
		sat_s7 <= any_sat;
	end

	assign out_valid = valid_q[BACK_LAT-1];
	assign out_data  = {res_s7[0], res_s7[1], res_s7[2], sat_s7};
endmodule
`default_nettype wire

// ===== sv/euler_xyz_vector_rotation_unit.sv =====
// path: an accepted request passes the cordic stages, one queue hop and the
//   7 back-end stages on its way to the head of the result queue
// throughput: one request per cycle; set by the one-step-per-stage cordic and
//   the fully pipelined matrix multiply, limited only by queue credit
// reset: arst_n clears the valid pipes, queue pointers and credit counters;
//   both queues come up empty and the block accepts at once
`default_nettype none
module euler_xyz_vector_rotation_unit
	import erot_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [COORD_BITS-1:0] point_x,
	input  wire logic [COORD_BITS-1:0] point_y,
	input  wire logic [COORD_BITS-1:0] point_z,
	input  wire logic [ANGLE_BITS-1:0] angle_x,
	input  wire logic [ANGLE_BITS-1:0] angle_y,
	input  wire logic [ANGLE_BITS-1:0] angle_z,
	output logic                       empty,
	input  wire logic                  pop,
	output logic      [COORD_BITS-1:0] rotated_x,
	output logic      [COORD_BITS-1:0] rotated_y,
	output logic      [COORD_BITS-1:0] rotated_z,
	output logic                       saturated
);
	localparam int MID_DEPTH = 32;
	localparam int OUT_DEPTH = 16;
	localparam int MID_W = 3*COORD_BITS + $bits(trig_set_t);
	localparam int OUT_W = 3*COORD_BITS + 1;
	localparam int FCW = $clog2(MID_DEPTH + 1);
	localparam int BCW = $clog2(OUT_DEPTH + 1);

	logic accept_in, issue, pop_out;
	logic [FCW-1:0] front_cnt_q;
	logic [BCW-1:0] back_cnt_q;
	logic front_valid, mid_empty, back_valid;
	logic [3*COORD_BITS-1:0] front_point, mid_point;
	trig_set_t front_trig, mid_trig;
	logic [MID_W-1:0] mid_rdata;
	logic [OUT_W-1:0] back_data, out_rdata;

	assign full      = (front_cnt_q == FCW'(MID_DEPTH));
	assign accept_in = push & ~full;
	assign issue     = ~mid_empty & (back_cnt_q < BCW'(OUT_DEPTH));
	assign pop_out   = pop & ~empty;

	// credit covers items in flight plus those waiting in the queue behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_cnt_q <= '0;
			back_cnt_q  <= '0;
		end else begin
			front_cnt_q <= front_cnt_q + FCW'(accept_in) - FCW'(issue);
			back_cnt_q  <= back_cnt_q + BCW'(issue) - BCW'(pop_out);
		end
	end

	erot_front #(.ANGLE_BITS(ANGLE_BITS), .COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(accept_in),
		.in_point({point_x, point_y, point_z}),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.out_valid(front_valid), .out_point(front_point), .out_trig(front_trig)
	);

	erot_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk(clk), .arst_n(arst_n), .push(front_valid), .wdata({front_point, front_trig}),
		.pop(issue), .rdata(mid_rdata), .empty(mid_empty)
	);

	assign mid_point = mid_rdata[MID_W-1 -: 3*COORD_BITS];
	assign mid_trig  = trig_set_t'(mid_rdata[$bits(trig_set_t)-1:0]);

	erot_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(issue), .in_point(mid_point),
		.in_trig(mid_trig), .out_valid(back_valid), .out_data(back_data)
	);

	erot_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk(clk), .arst_n(arst_n), .push(back_valid), .wdata(back_data),
		.pop(pop_out), .rdata(out_rdata), .empty(empty)
	);

	assign rotated_x = out_rdata[3*COORD_BITS -: COORD_BITS];
	assign rotated_y = out_rdata[2*COORD_BITS -: COORD_BITS];
	assign rotated_z = out_rdata[COORD_BITS -: COORD_BITS];
	assign saturated = out_rdata[0];
endmodule
`default_nettype wire

// ===== sv/erot_checker.sv =====
// port-level checks for the euler rotation unit and their bind
`default_nettype none
module erot_checker #(
	parameter int COORD_BITS = 32
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  push,
	input wire logic                  full,
	input wire logic                  empty,
	input wire logic                  pop,
	input wire logic [COORD_BITS-1:0] rotated_x,
	input wire logic [COORD_BITS-1:0] rotated_y,
	input wire logic [COORD_BITS-1:0] rotated_z,
	input wire logic                  saturated
);
	localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic [6:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 7'(push && !full) - 7'(pop && !empty);
		end
	end

	// no result without an outstanding request
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 7'd0) else $error("result with no pending request");

	// front and back credit together bound what is outstanding
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 7'd48) else $error("too many requests outstanding");

	// a clipped result shows at least one coordinate at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && saturated) |-> (rotated_x == CMAX || rotated_x == CMIN ||
		rotated_y == CMAX || rotated_y == CMIN || rotated_z == CMAX || rotated_z == CMIN))
		else $error("saturated flag with no coordinate at a rail");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty) else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(rotated_x) && $stable(rotated_y) &&
		$stable(rotated_z) && $stable(saturated))) else $error("stalled result changed");
endmodule

bind euler_xyz_vector_rotation_unit erot_checker #(.COORD_BITS(COORD_BITS)) u_erot_checker (.*);
`default_nettype wire

// ===== tb/euler_xyz_vector_rotation_unit_tb.sv =====
// testbench for the euler xyz rotation unit: queue handshakes, scoreboard against a predictor
`default_nettype none
module euler_xyz_vector_rotation_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import erot_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int N_RANDOM     = 1030;

	typedef struct {
		logic [31:0] rx;
		logic [31:0] ry;
		logic [31:0] rz;
		logic        sat;
	} rotated_t;

	class rotation_scoreboard;
		rotated_t pending[$];

		function automatic void sin_cos(input logic [15:0] ang, output longint s,
				output longint c);
			logic [31:0] turn;
			longint x, y, z, dx, dy, cq, sq;
			turn = {ang, 16'h0000};
			x = longint'(CORDIC_GAIN);
			y = 0;
			z = longint'(turn[29:0]);
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
				end else begin
					x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
				end
			end
			cq = q15(x);
			sq = q15(y);
			case (turn[31:30])
				2'd0: begin c = cq;  s = sq;  end
				2'd1: begin c = -sq; s = cq;  end
				2'd2: begin c = -cq; s = -sq; end
				default: begin c = sq; s = -cq; end
			endcase
		endfunction

		function automatic longint q15(input longint v);
			longint r;
			if (v < 0) v = 0;
			if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
			r = (v + 16384) >>> 15;
			return (r > 32767) ? 32767 : r;
		endfunction

		function automatic logic [31:0] dot(input longint m0, m1, m2,
				input logic signed [31:0] p0, p1, p2, inout logic sat);
			logic signed [127:0] acc, a, b, v;
			a = m0; b = p0; acc = a * b;
			a = m1; b = p1; acc += a * b;
			a = m2; b = p2; acc += a * b;
			acc += 128'sd1 <<< 44;
			v = acc >>> 45;
			if (v > 128'sd2147483647) begin
				v = 128'sd2147483647; sat = 1'b1;
			end
			if (v < -128'sd2147483648) begin
				v = -128'sd2147483648; sat = 1'b1;
			end
			return v[31:0];
		endfunction

		function void note(input logic [31:0] px, py, pz, input logic [15:0] ax, ay, az);
			longint sa, ca, sb, cb, sc, cc;
			longint k;
			rotated_t r;
			k = 32768;
			sin_cos(ax, sa, ca);
			sin_cos(ay, sb, cb);
			sin_cos(az, sc, cc);
			r.sat = 1'b0;
			r.rx = dot(cb * cc * k, -sc * cb * k, sb * k * k, px, py, pz, r.sat);
			r.ry = dot(sa * sb * cc + sc * ca * k, -sa * sb * sc + ca * cc * k,
				-sa * cb * k, px, py, pz, r.sat);
			r.rz = dot(sa * sc * k - sb * ca * cc, sa * cc * k + sb * sc * ca,
				ca * cb * k, px, py, pz, r.sat);
			pending.push_back(r);
		endfunction

		// returns an empty string when the result matches the oldest expectation
		function string check(input rotated_t got);
			rotated_t e;
			string msg;
			msg = "";
			if (pending.size() == 0) return "result with no request outstanding";
			e = pending.pop_front();
			if (got.rx !== e.rx) msg = {msg, $sformatf(" x got %h exp %h", got.rx, e.rx)};
			if (got.ry !== e.ry) msg = {msg, $sformatf(" y got %h exp %h", got.ry, e.ry)};
			if (got.rz !== e.rz) msg = {msg, $sformatf(" z got %h exp %h", got.rz, e.rz)};
			if (got.sat !== e.sat) msg = {msg, $sformatf(" sat got %b exp %b", got.sat, e.sat)};
			return msg;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
	logic full, empty, saturated;
	logic [31:0] rotated_x, rotated_y, rotated_z;

	rotation_scoreboard sb = new();
	int errors = 0;
	int cycles = 0;
	bit steady = 1'b0;

	euler_xyz_vector_rotation_unit u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.empty(empty), .pop(pop),
		.rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
		.saturated(saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic report(input string msg);
		errors++;
		$display("mismatch at cycle %0d:%s", cycles, msg);
	endtask

	// one request, held until accepted; caller is just after a rising edge
	task automatic send(input logic [31:0] px, py, pz, input logic [15:0] ax, ay, az);
		push <= 1'b1;
		point_x <= px; point_y <= py; point_z <= pz;
		angle_x <= ax; angle_y <= ay; angle_z <= az;
		do @(posedge clk); while (full);
		sb.note(px, py, pz, ax, ay, az);
		if (!steady && $urandom_range(99) < 33) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return 32'($signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000);
			1: return {{16{1'b0}}, 16'($urandom)} ^ {32{1'($urandom_range(1))}};
			default: return $urandom;
		endcase
	endfunction

	// receiver with random stalls and one long hold-off
	initial begin
		int popped, hold;
		bit held;
		rotated_t got;
		string msg;
		popped = 0; hold = 0; held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.rx = rotated_x; got.ry = rotated_y; got.rz = rotated_z;
				got.sat = saturated;
				msg = sb.check(got);
				if (msg != "") report(msg);
				popped++;
			end
			if (!held && popped == 300) begin
				held = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else begin
				pop <= (steady || $urandom_range(99) >= 33);
			end
		end
	end

	initial begin
		logic [15:0] angs [5];
		int w;
		angs = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero, extremes, quadrant boundaries, saturation
		send(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
		send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0, 16'h0, 16'h0);
		send(32'h80000000, 32'h80000000, 32'h80000000, 16'hffff, 16'hffff, 16'hffff);
		send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'd8192, 16'd8192, 16'd8192);
		send(32'h80000000, 32'h80000000, 32'h80000000, 16'd8192, 16'd57344, 16'd8192);
		send(32'h00010000, 32'hffff0000, 32'h00010000, 16'd32768, 16'd32768, 16'd32768);
		for (int i = 0; i < 5; i++)
			send(32'h00010000, 32'h00020000, 32'h00030000, angs[i], angs[(i + 1) % 5],
				angs[(i + 2) % 5]);
		for (int i = 0; i < 5; i++)
			send(32'h7fffffff, 32'h80000000, 32'h00000001, angs[(i + 3) % 5], angs[i],
				angs[(i + 4) % 5]);
		send(32'hffffffff, 32'h00000001, 32'hffffffff, 16'd1, 16'd16383, 16'd32767);
		push <= 1'b0;
		// sender pause until the pipeline has drained
		w = 0;
		while (sb.pending.size() != 0 && w < 10000) begin
			@(posedge clk);
			w++;
		end
		@(posedge clk);
		for (int n = 0; n < N_RANDOM; n++) begin
			steady = (n >= 500 && n < 650);
			send(rand_coord(), rand_coord(), rand_coord(),
				16'($urandom), 16'($urandom), 16'($urandom));
		end
		push <= 1'b0;
		steady = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/erot_pkg.sv
sv/erot_fifo.sv
sv/erot_sincos.sv
sv/erot_front.sv
sv/erot_back.sv
sv/euler_xyz_vector_rotation_unit.sv
sv/erot_checker.sv
tb/euler_xyz_vector_rotation_unit_tb.sv
